[sv/cfr_pkg.sv]
package cfr_pkg;

    // command codes
    localparam logic [7:0] OPC_PING       = 8'h01;
    localparam logic [7:0] OPC_LOAD_BLOCK = 8'h23;
    localparam logic [7:0] OPC_STROBE     = 8'h42;

    // reply codes as carried on the result word
    localparam logic REPLY_ACK  = 1'b0;
    localparam logic REPLY_NACK = 1'b1;

    // crc-32 generator, msb first
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // packed widths of the stream words
    localparam int RX_DATA_W  = 8;
    localparam int RX_USER_W  = 2;
    localparam int RES_BITS   = 20;
    localparam int RES_DATA_W = 24;

    // parser states
    typedef enum logic [5:0] {
        ST_CMD     = 6'b000001,
        ST_IDX     = 6'b000010,
        ST_DATA    = 6'b000100,
        ST_CHK_LO  = 6'b001000,
        ST_CHK_HI  = 6'b010000,
        ST_INVALID = 6'b100000
    } cfr_state_t;

    // one received word
    typedef struct packed {
        logic       line_idle;
        logic       overrun;
        logic [7:0] rx_byte;
    } cfr_rx_t;

    // one result word
    typedef struct packed {
        logic       strobe_res;
        logic [7:0] write_data;
        logic [3:0] write_offset;
        logic [3:0] write_block;
        logic       write_valid;
        logic       reply_code;
        logic       reply_valid;
    } cfr_result_t;

    typedef logic [31:0][31:0] crc_cols_t;

    // response of 32 shift steps to each single input bit
    function automatic crc_cols_t crc_build_cols();
        crc_cols_t   cols;
        logic [31:0] c;
        for (int i = 0; i < 32; i++)
        begin
            c = 32'(1) << i;
            for (int j = 0; j < 32; j++)
            begin
                c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            cols[i] = c;
        end
        return cols;
    endfunction

    localparam crc_cols_t CRC_COLS = crc_build_cols();

    // one zero-extended byte word through the crc, as a flat xor network
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] x;
        logic [31:0] acc;
        x   = crc ^ {24'd0, b};
        acc = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                acc = acc ^ CRC_COLS[i];
            end
        end
        return acc;
    endfunction

endpackage

[sv/crc_checked_command_frame_receiver_top.sv]
// command frame receiver with crc check
// slave side: one word per received serial byte; s_tdata is the byte,
// s_tuser carries the overrun and idle-line flags of that byte
// master side: exactly one result word per slave word, carrying the
// ack/nack reply, a frame-buffer byte write and the strobe flag
// frames: command byte (ping, set-block, strobe); set-block adds a block
// index and BLOCK_BYTES data bytes; all end in a little-endian 16-bit check
// compared with the low half of a crc-32 over the frame bytes
// throughput: one word per cycle, back to back while m_tready is high; the crc
// update is a single xor network between the input register and the crc register
// path: an accepted word sits in the input register and moves to the result
// register when that is free; m_tvalid is driven by the result register
// stall: while m_tready is low the result register holds and the input
// register takes one more word, then s_tready drops
// reset: both registers empty, parser in the command state
module crc_checked_command_frame_receiver_top #(
    parameter int NUM_BLOCKS  = 16,
    parameter int BLOCK_BYTES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // rx_byte
    input  logic [cfr_pkg::RX_DATA_W-1:0]  s_tdata,
    // overrun, line_idle
    input  logic [cfr_pkg::RX_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // reply_valid, reply_code, write_valid, write_block[4], write_offset[4],
    // write_data[8], strobe_res, zero pad[4]
    output logic [cfr_pkg::RES_DATA_W-1:0] m_tdata
);

    cfr_pkg::cfr_rx_t     s_word;
    cfr_pkg::cfr_rx_t     hold_word;
    logic                 hold_valid;
    logic                 advance;
    cfr_pkg::cfr_result_t res;
    cfr_pkg::cfr_result_t res_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    assign s_word.rx_byte   = s_tdata;
    assign s_word.overrun   = s_tuser[0];
    assign s_word.line_idle = s_tuser[1];

    // held word moves into the result register when that is free
    assign advance = hold_valid && (!out_valid_reg || m_tready);

    cfr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_word     (s_word),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_word  (hold_word)
    );

    cfr_parser #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .rx    (hold_word),
        .res   (res)
    );

    // result register valid
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(cfr_pkg::RES_DATA_W - cfr_pkg::RES_BITS)'(0), res_reg};

endmodule

[sv/cfr_in_stage.sv]
module cfr_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  cfr_pkg::cfr_rx_t s_word,
    input  logic            advance,
    output logic            hold_valid,
    output cfr_pkg::cfr_rx_t hold_word
);

    logic             valid_reg;
    logic             valid_next;
    cfr_pkg::cfr_rx_t word_reg;

    // free when empty or when the held word moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !advance);

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            word_reg <= s_word;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_word  = word_reg;

endmodule

[sv/cfr_parser.sv]
module cfr_parser #(
    parameter int NUM_BLOCKS  = 16,
    parameter int BLOCK_BYTES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  cfr_pkg::cfr_rx_t     rx,
    output cfr_pkg::cfr_result_t res
);

    localparam int CNT_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

    cfr_pkg::cfr_state_t state_reg, state_next;
    logic                is_strobe_reg, is_strobe_next;
    logic [31:0]         crc_reg, crc_next;
    logic [7:0]          check_lo_reg, check_lo_next;
    logic [3:0]          block_reg, block_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W+3:0]    count_ext;
    logic                count_last;
    logic                block_bad;
    logic [31:0]         crc_of_byte;

    assign count_ext   = {4'd0, count_reg};
    assign count_last  = (count_reg == CNT_W'(BLOCK_BYTES - 1));
    assign block_bad   = ({1'b0, rx.rx_byte} >= 9'(NUM_BLOCKS));
    assign crc_of_byte = cfr_pkg::crc_step(
        (state_reg == cfr_pkg::ST_CMD) ? cfr_pkg::CRC_INIT : crc_reg, rx.rx_byte);

    // next state and result for the word at hand
    always_comb
    begin
        res            = '0;
        state_next     = state_reg;
        is_strobe_next = is_strobe_reg;
        crc_next       = crc_reg;
        check_lo_next  = check_lo_reg;
        block_next     = block_reg;
        count_next     = count_reg;
        if (rx.overrun)
        begin
            res.reply_valid = 1'b1;
            res.reply_code  = cfr_pkg::REPLY_NACK;
            state_next      = cfr_pkg::ST_INVALID;
        end
        else if (rx.line_idle)
        begin
            state_next = cfr_pkg::ST_CMD;
        end
        else
        begin
            case (state_reg)
                cfr_pkg::ST_CMD:
                begin
                    is_strobe_next = (rx.rx_byte == cfr_pkg::OPC_STROBE);
                    crc_next       = crc_of_byte;
                    if (rx.rx_byte == cfr_pkg::OPC_LOAD_BLOCK)
                    begin
                        state_next = cfr_pkg::ST_IDX;
                    end
                    else if (rx.rx_byte inside {cfr_pkg::OPC_PING, cfr_pkg::OPC_STROBE})
                    begin
                        state_next = cfr_pkg::ST_CHK_LO;
                    end
                    else
                    begin
                        res.reply_valid = 1'b1;
                        res.reply_code  = cfr_pkg::REPLY_NACK;
                        state_next      = cfr_pkg::ST_INVALID;
                    end
                end
                cfr_pkg::ST_IDX:
                begin
                    if (block_bad)
                    begin
                        res.reply_valid = 1'b1;
                        res.reply_code  = cfr_pkg::REPLY_NACK;
                        state_next      = cfr_pkg::ST_INVALID;
                    end
                    else
                    begin
                        crc_next   = crc_of_byte;
                        block_next = rx.rx_byte[3:0];
                        count_next = '0;
                        state_next = cfr_pkg::ST_DATA;
                    end
                end
                cfr_pkg::ST_DATA:
                begin
                    res.write_valid  = 1'b1;
                    res.write_block  = block_reg;
                    res.write_offset = count_ext[3:0];
                    res.write_data   = rx.rx_byte;
                    crc_next         = crc_of_byte;
                    count_next       = count_reg + CNT_W'(1);
                    if (count_last)
                    begin
                        state_next = cfr_pkg::ST_CHK_LO;
                    end
                end
                cfr_pkg::ST_CHK_LO:
                begin
                    check_lo_next = rx.rx_byte;
                    state_next    = cfr_pkg::ST_CHK_HI;
                end
                cfr_pkg::ST_CHK_HI:
                begin
                    res.reply_valid = 1'b1;
                    if ({rx.rx_byte, check_lo_reg} != crc_reg[15:0])
                    begin
                        res.reply_code = cfr_pkg::REPLY_NACK;
                        state_next     = cfr_pkg::ST_INVALID;
                    end
                    else
                    begin
                        res.reply_code = cfr_pkg::REPLY_ACK;
                        res.strobe_res = is_strobe_reg;
                        state_next     = cfr_pkg::ST_CMD;
                    end
                end
                cfr_pkg::ST_INVALID:
                begin
                    state_next = cfr_pkg::ST_INVALID;
                end
                default:
                begin
                    res.reply_valid = 1'b1;
                    res.reply_code  = cfr_pkg::REPLY_NACK;
                    state_next      = cfr_pkg::ST_INVALID;
                end
            endcase
        end
    end

    // parser state, updated once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfr_pkg::ST_CMD;
            is_strobe_reg <= 1'b0;
            crc_reg       <= cfr_pkg::CRC_INIT;
            check_lo_reg  <= '0;
            block_reg     <= '0;
            count_reg     <= '0;
        end
        else if (step)
        begin
            state_reg     <= state_next;
            is_strobe_reg <= is_strobe_next;
            crc_reg       <= crc_next;
            check_lo_reg  <= check_lo_next;
            block_reg     <= block_next;
            count_reg     <= count_next;
        end
    end

    // a write only comes out of the data phase
    assert property (@(posedge clk) disable iff (!rst_n)
        res.write_valid |-> (state_reg == cfr_pkg::ST_DATA))
        else $error("write outside data phase");

    // a strobe always rides on an ack
    assert property (@(posedge clk) disable iff (!rst_n)
        res.strobe_res |-> (res.reply_valid && (res.reply_code == cfr_pkg::REPLY_ACK)))
        else $error("strobe without ack");

    // an overrun word always lands in the invalid state
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && rx.overrun) |=> (state_reg == cfr_pkg::ST_INVALID))
        else $error("overrun did not invalidate");

    // the last data word hands over to the check phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && !rx.overrun && !rx.line_idle && (state_reg == cfr_pkg::ST_DATA) && count_last)
        |=> (state_reg == cfr_pkg::ST_CHK_LO))
        else $error("data phase overran block");

    // the invalid state stays silent
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == cfr_pkg::ST_INVALID) && !rx.overrun) |-> !res.reply_valid)
        else $error("reply from invalid state");

endmodule

[verif/testbench.sv]
// crc-32 of one byte entered as a zero-extended 32-bit word, msb first
function automatic logic [31:0] crc32_word_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 32; i++)
    begin
        c = c[31] ? ((c << 1) ^ cfr_pkg::CRC_POLY) : (c << 1);
    end
    return c;
endfunction

// frame parser prediction and reply checking
class frame_reply_tracker #(int NBLK = 16, int NBYTES = 16);
    cfr_pkg::cfr_state_t  parse_st;
    logic [7:0]           cmd_byte;
    logic [31:0]          crc_acc;
    logic [15:0]          check_rx;
    logic [3:0]           blk_idx;
    int unsigned          byte_cnt;
    cfr_pkg::cfr_result_t pending_replies[$];
    int unsigned          n_errors;
    int unsigned          n_checked;

    function new();
        parse_st  = cfr_pkg::ST_CMD;
        cmd_byte  = '0;
        crc_acc   = cfr_pkg::CRC_INIT;
        check_rx  = '0;
        blk_idx   = '0;
        byte_cnt  = 0;
        n_errors  = 0;
        n_checked = 0;
    endfunction

    task report(input string msg);
        n_errors++;
        if (n_errors <= 100)
        begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // advance the parser by one received word and queue its reply
    function void accept_rx(input cfr_pkg::cfr_rx_t w);
        cfr_pkg::cfr_result_t r;
        r = '0;
        if (w.overrun)
        begin
            r.reply_valid = 1'b1;
            r.reply_code  = cfr_pkg::REPLY_NACK;
            parse_st      = cfr_pkg::ST_INVALID;
        end
        else if (w.line_idle)
        begin
            parse_st = cfr_pkg::ST_CMD;
        end
        else
        begin
            case (parse_st)
                cfr_pkg::ST_CMD:
                begin
                    cmd_byte = w.rx_byte;
                    crc_acc  = crc32_word_update(cfr_pkg::CRC_INIT, w.rx_byte);
                    if (w.rx_byte == cfr_pkg::OPC_LOAD_BLOCK)
                    begin
                        parse_st = cfr_pkg::ST_IDX;
                    end
                    else if (w.rx_byte == cfr_pkg::OPC_PING || w.rx_byte == cfr_pkg::OPC_STROBE)
                    begin
                        parse_st = cfr_pkg::ST_CHK_LO;
                    end
                    else
                    begin
                        r.reply_valid = 1'b1;
                        r.reply_code  = cfr_pkg::REPLY_NACK;
                        parse_st      = cfr_pkg::ST_INVALID;
                    end
                end
                cfr_pkg::ST_IDX:
                begin
                    if (w.rx_byte >= NBLK)
                    begin
                        r.reply_valid = 1'b1;
                        r.reply_code  = cfr_pkg::REPLY_NACK;
                        parse_st      = cfr_pkg::ST_INVALID;
                    end
                    else
                    begin
                        crc_acc  = crc32_word_update(crc_acc, w.rx_byte);
                        blk_idx  = w.rx_byte[3:0];
                        byte_cnt = 0;
                        parse_st = cfr_pkg::ST_DATA;
                    end
                end
                cfr_pkg::ST_DATA:
                begin
                    r.write_valid  = 1'b1;
                    r.write_block  = blk_idx;
                    r.write_offset = byte_cnt[3:0];
                    r.write_data   = w.rx_byte;
                    crc_acc        = crc32_word_update(crc_acc, w.rx_byte);
                    byte_cnt++;
                    if (byte_cnt >= NBYTES)
                    begin
                        parse_st = cfr_pkg::ST_CHK_LO;
                    end
                end
                cfr_pkg::ST_CHK_LO:
                begin
                    check_rx = {8'h00, w.rx_byte};
                    parse_st = cfr_pkg::ST_CHK_HI;
                end
                cfr_pkg::ST_CHK_HI:
                begin
                    check_rx[15:8] = w.rx_byte;
                    r.reply_valid  = 1'b1;
                    if (check_rx != crc_acc[15:0])
                    begin
                        r.reply_code = cfr_pkg::REPLY_NACK;
                        parse_st     = cfr_pkg::ST_INVALID;
                    end
                    else
                    begin
                        r.reply_code = cfr_pkg::REPLY_ACK;
                        parse_st     = cfr_pkg::ST_CMD;
                        r.strobe_res = (cmd_byte == cfr_pkg::OPC_STROBE);
                    end
                end
                cfr_pkg::ST_INVALID:
                begin
                end
                default:
                begin
                    r.reply_valid = 1'b1;
                    r.reply_code  = cfr_pkg::REPLY_NACK;
                    parse_st      = cfr_pkg::ST_INVALID;
                end
            endcase
        end
        pending_replies.push_back(r);
    endfunction

    // compare one result word with the oldest queued reply
    task check_reply(input cfr_pkg::cfr_result_t got);
        cfr_pkg::cfr_result_t want;
        string                bad;
        if (pending_replies.size() == 0)
        begin
            report($sformatf("result %h arrived with none outstanding", got));
            return;
        end
        want = pending_replies.pop_front();
        bad  = "";
        if (got.reply_valid !== want.reply_valid)
            bad = {bad, " reply_valid"};
        if (got.reply_code !== want.reply_code)
            bad = {bad, " reply_code"};
        if (got.write_valid !== want.write_valid)
            bad = {bad, " write_valid"};
        if (got.write_block !== want.write_block)
            bad = {bad, " write_block"};
        if (got.write_offset !== want.write_offset)
            bad = {bad, " write_offset"};
        if (got.write_data !== want.write_data)
            bad = {bad, " write_data"};
        if (got.strobe_res !== want.strobe_res)
            bad = {bad, " strobe_res"};
        if (bad != "")
        begin
            report($sformatf("result %0d:%s wrong, got %h want %h", n_checked, bad, got, want));
        end
        n_checked++;
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLK         = 16;
    localparam int BLK_BYTES       = 16;
    localparam int QUIET_LIMIT     = 3000;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 275;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [cfr_pkg::RX_DATA_W-1:0]  s_tdata  = '0;
    logic [cfr_pkg::RX_USER_W-1:0]  s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [cfr_pkg::RES_DATA_W-1:0] m_tdata;

    frame_reply_tracker #(NUM_BLK, BLK_BYTES) replies;

    // handshakes as seen between edges
    logic                 in_fire  = 1'b0;
    logic                 out_fire = 1'b0;
    cfr_pkg::cfr_rx_t     in_word  = '0;
    cfr_pkg::cfr_result_t out_word = '0;

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned words_sent     = 0;
    int unsigned hold_asks      = 0;
    int unsigned hold_served    = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;

    logic [7:0] frame_q[$];

    always #6 clk = ~clk;

    crc_checked_command_frame_receiver_top #(
        .NUM_BLOCKS  (NUM_BLK),
        .BLOCK_BYTES (BLK_BYTES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // sample both sides mid-cycle, when everything is settled
    always @(negedge clk)
    begin
        in_fire  <= rst_n && s_tvalid && s_tready;
        in_word  <= {s_tuser[1], s_tuser[0], s_tdata};
        out_fire <= rst_n && m_tvalid && m_tready;
        out_word <= m_tdata[cfr_pkg::RES_BITS-1:0];
    end

    // predict, check, and watch for a hang
    always @(posedge clk)
    begin
        if (in_fire)
            replies.accept_rx(in_word);
        if (out_fire)
            replies.check_reply(out_word);
        if (in_fire || out_fire)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_served)
        begin
            m_tready    <= 1'b0;
            hold_served <= hold_asks;
            hold_left   <= HOLD_CYCLES;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // offer one word and wait until it is taken
    task automatic send_word(input logic [7:0] b, input logic ovr, input logic idle);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {idle, ovr};
        @(posedge clk);
        while (!in_fire)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_idle();
        send_word(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // command, optional block index and data, then the little-endian check
    function automatic void build_frame(input logic [7:0] cmd, input logic [7:0] blk,
                                        input logic bad_check, input int fill);
        logic [31:0] crc;
        logic [7:0]  b;
        frame_q.delete();
        frame_q.push_back(cmd);
        if (cmd == cfr_pkg::OPC_LOAD_BLOCK)
        begin
            frame_q.push_back(blk);
            for (int i = 0; i < BLK_BYTES; i++)
            begin
                case (fill)
                    1:       b = 8'h00;
                    2:       b = 8'hFF;
                    3:       b = 8'(i * 17);
                    default: b = 8'($urandom_range(255));
                endcase
                frame_q.push_back(b);
            end
        end
        crc = cfr_pkg::CRC_INIT;
        foreach (frame_q[i])
            crc = crc32_word_update(crc, frame_q[i]);
        if (bad_check)
            crc[15:0] = crc[15:0] ^ 16'(1 << $urandom_range(15));
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
    endfunction

    // play the built frame; optionally break it at one word by overrun or idle
    task automatic play_frame(input int stop_at, input logic stop_ovr);
        for (int i = 0; i < frame_q.size(); i++)
        begin
            if (i == stop_at)
            begin
                if (stop_ovr)
                begin
                    send_word(frame_q[i], 1'b1, 1'($urandom_range(1)));
                    send_idle();
                end
                else
                begin
                    send_word(frame_q[i], 1'b0, 1'b1);
                end
                return;
            end
            send_word(frame_q[i], 1'b0, 1'b0);
        end
    endtask

    // mostly well-formed frames, some broken ones and line noise
    task automatic random_frame();
        int unsigned pick;
        logic [7:0]  cmd;
        logic [7:0]  junk;
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0:       cmd = cfr_pkg::OPC_PING;
            1:       cmd = cfr_pkg::OPC_STROBE;
            default: cmd = cfr_pkg::OPC_LOAD_BLOCK;
        endcase
        if ($urandom_range(9) == 0)
            send_idle();
        if (pick < 70)
        begin
            build_frame(cmd, 8'($urandom_range(NUM_BLK - 1)), 1'b0, $urandom_range(3));
            play_frame(-1, 1'b0);
        end
        else if (pick < 80)
        begin
            // bad check, then garbage until the line goes idle
            build_frame(cmd, 8'($urandom_range(NUM_BLK - 1)), 1'b1, 0);
            play_frame(-1, 1'b0);
            repeat ($urandom_range(2))
                send_word(8'($urandom_range(255)), 1'b0, 1'b0);
            send_idle();
        end
        else if (pick < 85)
        begin
            do
                junk = 8'($urandom_range(255));
            while (junk == cfr_pkg::OPC_PING || junk == cfr_pkg::OPC_STROBE ||
                   junk == cfr_pkg::OPC_LOAD_BLOCK);
            send_word(junk, 1'b0, 1'b0);
            repeat ($urandom_range(3))
                send_word(8'($urandom_range(255)), 1'b0, 1'b0);
            send_idle();
        end
        else if (pick < 90)
        begin
            send_word(cfr_pkg::OPC_LOAD_BLOCK, 1'b0, 1'b0);
            send_word(8'($urandom_range(255, NUM_BLK)), 1'b0, 1'b0);
            send_idle();
        end
        else
        begin
            build_frame(cmd, 8'($urandom_range(NUM_BLK - 1)), 1'b0, 0);
            play_frame($urandom_range(frame_q.size() - 1), pick < 95);
        end
    endtask

    initial
    begin
        int unsigned target;
        replies = new();
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle line while waiting for a command
        send_idle();
        // good ping and good strobe
        build_frame(cfr_pkg::OPC_PING, 8'h00, 1'b0, 0);
        play_frame(-1, 1'b0);
        build_frame(cfr_pkg::OPC_STROBE, 8'h00, 1'b0, 0);
        play_frame(-1, 1'b0);
        // strobe with a bad check: nack once, following byte ignored
        build_frame(cfr_pkg::OPC_STROBE, 8'h00, 1'b1, 0);
        play_frame(-1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_idle();
        // unknown commands at both extremes
        send_word(8'h00, 1'b0, 1'b0);
        send_idle();
        send_word(8'hFF, 1'b0, 1'b0);
        send_idle();
        // block index just past the end and at the top
        send_word(cfr_pkg::OPC_LOAD_BLOCK, 1'b0, 1'b0);
        send_word(8'(NUM_BLK), 1'b0, 1'b0);
        send_idle();
        send_word(cfr_pkg::OPC_LOAD_BLOCK, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_idle();
        // overrun wins over a simultaneous idle line
        send_word(8'hA5, 1'b1, 1'b1);
        send_idle();

        // random traffic under four idling patterns
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct <= 0;
                    hold_asks      <= hold_asks + 1;
                end
                1:
                begin
                    src_idle_pct   = 56;
                    sink_stall_pct <= 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct <= 56;
                end
                default:
                begin
                    src_idle_pct   = 30;
                    sink_stall_pct <= 30;
                end
            endcase
            target = words_sent + ITEMS_PER_PHASE;
            while (words_sent < target)
                random_frame();
        end
        s_tvalid <= 1'b0;

        // drain, then allow for the two-stage pipeline
        while (replies.pending_replies.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (replies.pending_replies.size() != 0)
            replies.report("results still outstanding at the end");

        if (replies.n_errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
